>>> sv/isu_pkg.sv
// Shared types and constants for the indexed sequence store unit.
// No dependencies; imported by every module of the block.
package isu_pkg;

  localparam int WORD_W      = 32;
  localparam int FUNC_W      = 3;
  localparam int POS_W       = 6;
  localparam int COUNT_W     = 7;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;  // value + position, padded to 5 bytes
  localparam int OUT_TDATA_W = 40;  // read_value + count, padded to 5 bytes

  // request codes carried on the input tuser
  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_AT    = 3'd2,
    FN_DELETE    = 3'd3,
    FN_READ      = 3'd4,
    FN_SORT      = 3'd5
  } func_e;

  // result status carried on the output tuser
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // what every cell in the row does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_SORT   = 2'd3
  } cell_op_e;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_SORT = 1'b1
  } fsm_e;

  // broadcast control from the sequencer to the cell row
  typedef struct packed {
    cell_op_e            op;
    logic [WORD_W-1:0]   word;   // word to insert
    logic                phase;  // odd-even exchange phase
  } cell_ctl_t;

endpackage

>>> sv/isu_cell.sv
// One storage cell of the sequence row: holds one word and moves it to or
// from its neighbors for insert, delete and odd-even exchange. Uses isu_pkg.
module isu_cell #(
  parameter int IDX  = 0,
  parameter int CMPW = 7
) (
  input  logic                      clk_i,
  input  isu_pkg::cell_ctl_t        ctl_i,
  input  logic [CMPW-1:0]           pos_i,   // target index of insert/delete
  input  logic [CMPW-1:0]           len_i,   // stored entries before the op
  input  logic [isu_pkg::WORD_W-1:0] prev_i, // word of cell IDX-1
  input  logic [isu_pkg::WORD_W-1:0] next_i, // word of cell IDX+1
  output logic [isu_pkg::WORD_W-1:0] word_o
);
  import isu_pkg::*;

  localparam logic            PARITY   = 1'(IDX % 2);
  localparam logic            HAS_LEFT = (IDX > 0);
  localparam logic [CMPW-1:0] MY_IDX   = CMPW'(IDX);
  localparam logic [CMPW-1:0] NXT_IDX  = CMPW'(IDX + 1);

  logic [WORD_W-1:0] word_q, word_d;
  logic              in_list, right_in_list;
  logic              mine_gt_next, prev_gt_mine;

  // pair membership and signed compares for the exchange step
  assign in_list       = MY_IDX < len_i;
  assign right_in_list = NXT_IDX < len_i;
  assign mine_gt_next  = $signed(word_q) > $signed(next_i);
  assign prev_gt_mine  = $signed(prev_i) > $signed(word_q);

  // next word
  always_comb begin
    word_d = word_q;
    case (ctl_i.op)
      CELL_INSERT: begin
        if (MY_IDX == pos_i) begin
          word_d = ctl_i.word;
        end else if (MY_IDX > pos_i) begin
          word_d = prev_i;
        end
      end
      CELL_DELETE: begin
        if (MY_IDX >= pos_i) begin
          word_d = next_i;
        end
      end
      CELL_SORT: begin
        if (PARITY == ctl_i.phase) begin
          // left side of a pair
          if (right_in_list && mine_gt_next) begin
            word_d = next_i;
          end
        end else if (HAS_LEFT && in_list && prev_gt_mine) begin
          // right side of a pair
          word_d = prev_i;
        end
      end
      default: word_d = word_q;
    endcase
  end

  // storage: no reset, entries beyond the count are never read
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

>>> sv/indexed_sequence_store_unit.sv
// Indexed sequence store: a row of shifting cells with insert, delete, read
// and odd-even exchange sort. Result is registered in the cycle after accept
// for all requests but sort; a sort of n >= 2 entries takes n exchange
// phases through the cell row, then the result is registered. Non-sort
// requests can be taken one per cycle while the output is not stalled.
// Reset clears the count, the sequencer and the output stage, not the cells.
module indexed_sequence_store_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] value, [37:32] position, [39:38] zero
  input  logic [isu_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // [2:0] func
  input  logic [isu_pkg::FUNC_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] read_value, [38:32] count, [39] zero
  output logic [isu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [isu_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import isu_pkg::*;

  localparam int LW   = $clog2(CAPACITY + 1);
  localparam int IW   = $clog2(CAPACITY);
  localparam int CMPW = (LW > POS_W) ? LW : POS_W;
  localparam logic [LW-1:0]   ONE_L   = LW'(1);
  localparam logic [CMPW-1:0] CAP_EXT = CMPW'(CAPACITY);

  // state
  fsm_e              state_q, state_d;
  logic [LW-1:0]     length_q, length_d;
  logic [LW-1:0]     phase_q, phase_d;
  logic              out_valid_q;
  logic [WORD_W-1:0] out_rd_q;
  logic [COUNT_W-1:0] out_cnt_q;
  status_e           out_st_q;

  // request fields
  func_e             func;
  logic [WORD_W-1:0] in_value;
  logic [POS_W-1:0]  in_pos;
  logic              in_fire, out_free;
  logic [CMPW-1:0]   pos_ext, len_ext, ins_pos;
  logic              last_phase;

  // sequencer outputs
  cell_ctl_t         ctl;
  logic [CMPW-1:0]   cell_pos;
  logic              load;
  logic              sort_start;
  status_e           st;
  logic [WORD_W-1:0] rd;

  logic [WORD_W-1:0] words [CAPACITY];

  assign func     = func_e'(s_axis_tuser);
  assign in_value = s_axis_tdata[WORD_W-1:0];
  assign in_pos   = s_axis_tdata[WORD_W +: POS_W];
  assign pos_ext  = CMPW'(in_pos);
  assign len_ext  = CMPW'(length_q);

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == FSM_IDLE) && out_free;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign last_phase    = phase_q == (length_q - ONE_L);

  // insert target for the three insert kinds
  always_comb begin
    case (func)
      FN_INS_FRONT: ins_pos = '0;
      FN_INS_BACK:  ins_pos = len_ext;
      default:      ins_pos = pos_ext;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      FSM_IDLE: if (sort_start) state_d = FSM_SORT;
      FSM_SORT: if (last_phase) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // sequencer outputs: cell command, new count, result
  always_comb begin
    ctl.op     = CELL_HOLD;
    ctl.word   = in_value;
    ctl.phase  = phase_q[0];
    cell_pos   = pos_ext;
    length_d   = length_q;
    load       = 1'b0;
    sort_start = 1'b0;
    st         = ST_OK;
    rd         = '0;
    case (state_q)
      FSM_IDLE: begin
        if (in_fire) begin
          load = 1'b1;
          case (func)
            FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
              cell_pos = ins_pos;
              if (ins_pos > len_ext) begin
                st = ST_RANGE;
              end else if (len_ext == CAP_EXT) begin
                st = ST_FULL;
              end else begin
                ctl.op   = CELL_INSERT;
                length_d = length_q + ONE_L;
              end
            end
            FN_DELETE: begin
              if (length_q == '0) begin
                st = ST_EMPTY;
              end else if (pos_ext >= len_ext) begin
                st = ST_RANGE;
              end else begin
                ctl.op   = CELL_DELETE;
                length_d = length_q - ONE_L;
              end
            end
            FN_READ: begin
              if (length_q == '0) begin
                st = ST_EMPTY;
              end else if (pos_ext >= len_ext) begin
                st = ST_RANGE;
              end else begin
                rd = words[pos_ext[IW-1:0]];
              end
            end
            FN_SORT: begin
              // zero or one entry is already sorted
              if (length_q > ONE_L) begin
                load       = 1'b0;
                sort_start = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      FSM_SORT: begin
        ctl.op = CELL_SORT;
        load   = last_phase;
      end
      default: ;
    endcase
  end

  // exchange phase counter
  always_comb begin
    phase_d = phase_q;
    if (sort_start) begin
      phase_d = '0;
    end else if (state_q == FSM_SORT) begin
      phase_d = phase_q + ONE_L;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      length_q    <= '0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      length_q <= length_d;
      phase_q  <= phase_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_rd_q  <= rd;
      out_cnt_q <= COUNT_W'(length_d);
      out_st_q  <= st;
    end
  end

  // cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_prev
      assign prev_w = words[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = '0;
    end else begin : g_next
      assign next_w = words[i+1];
    end
    isu_cell #(
      .IDX  (i),
      .CMPW (CMPW)
    ) u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl),
      .pos_i  (cell_pos),
      .len_i  (len_ext),
      .prev_i (prev_w),
      .next_i (next_w),
      .word_o (words[i])
    );
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_cnt_q, out_rd_q};
  assign m_axis_tuser  = out_st_q;

endmodule

>>> sv/isu_checker.sv
// Port-level checks for indexed_sequence_store_unit, bound to the top level.
// Uses isu_pkg for field widths and status codes.
module isu_checker #(
  parameter int CAPACITY = 64
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [isu_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic [isu_pkg::STATUS_W-1:0]     m_axis_tuser
);
  import isu_pkg::*;

  localparam logic [COUNT_W-1:0] CAP_CNT = COUNT_W'(CAPACITY);

  logic [WORD_W-1:0]  rd_v;
  logic [COUNT_W-1:0] cnt_v;

  assign rd_v  = m_axis_tdata[WORD_W-1:0];
  assign cnt_v = m_axis_tdata[WORD_W +: COUNT_W];

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // only a successful read returns data
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != ST_OK) |-> rd_v == '0)
    else $error("nonzero read_value on failed request");

  // full only at capacity
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_FULL) |-> cnt_v == CAP_CNT)
    else $error("full status below capacity");

  // empty only with no entries
  a_empty_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |-> cnt_v == '0)
    else $error("empty status with entries stored");

  // count never above capacity
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (CAPACITY > 127) || (cnt_v <= CAP_CNT))
    else $error("count above capacity");

endmodule

bind indexed_sequence_store_unit isu_checker #(
  .CAPACITY (CAPACITY)
) u_isu_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

>>> bench/tb.sv
// Self-checking bench for indexed_sequence_store_unit: directed edge cases,
// then random insert/delete/read/sort traffic checked against a local model.
// Depends on isu_pkg and the unit's RTL only.
module tb;
  import isu_pkg::*;

  localparam int CAPACITY = 64;
  localparam int MAX_IDLE = 18;
  localparam int MAX_SHOWN = 10;

  // function codes the unit does not define; they must answer ok, no change
  localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
  localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

  localparam logic [WORD_W-1:0] WORD_MAX = 32'h7fff_ffff;
  localparam logic [WORD_W-1:0] WORD_MIN = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_NEG1 = 32'hffff_ffff;

  typedef struct packed {
    logic [WORD_W-1:0]  read_value;
    logic [COUNT_W-1:0] count;
    status_e            status;
  } result_t;

  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_SHRINK,
    MIX_BALANCED
  } mix_e;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // [31:0] value, [37:32] position, [39:38] zero
  logic [IN_TDATA_W-1:0] s_axis_tdata;
  // [2:0] func
  logic [FUNC_W-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // [31:0] read_value, [38:32] count, [39] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  // [1:0] status
  logic [STATUS_W-1:0] m_axis_tuser;

  // local copy of the stored sequence, updated at each accepted request
  logic signed [WORD_W-1:0] seq_words [CAPACITY];
  int seq_len;

  result_t pending_results[$];
  int fail_count;
  bit tx_quiet;
  bit rx_quiet;

  indexed_sequence_store_unit #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // hard stop in case the unit hangs
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("%s", msg);
  endfunction

  // apply one request to the local sequence and return the expected answer
  function automatic result_t apply_request(input logic [FUNC_W-1:0] fn,
                                            input logic [WORD_W-1:0] word,
                                            input logic [POS_W-1:0] pos);
    result_t r;
    int i;
    int j;
    int at;
    logic signed [WORD_W-1:0] w;
    r.read_value = '0;
    r.status = ST_OK;
    case (fn)
      FN_INS_FRONT, FN_INS_BACK, FN_INS_AT: begin
        if (fn == FN_INS_FRONT) at = 0;
        else if (fn == FN_INS_BACK) at = seq_len;
        else at = int'(pos);
        // range is checked ahead of fullness
        if (at > seq_len) begin
          r.status = ST_RANGE;
        end else if (seq_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          for (i = seq_len; i > at; i--) seq_words[i] = seq_words[i-1];
          seq_words[at] = word;
          seq_len++;
        end
      end
      FN_DELETE: begin
        if (seq_len == 0) begin
          r.status = ST_EMPTY;
        end else if (int'(pos) >= seq_len) begin
          r.status = ST_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < seq_len; i++) seq_words[i] = seq_words[i+1];
          seq_len--;
        end
      end
      FN_READ: begin
        if (seq_len == 0) r.status = ST_EMPTY;
        else if (int'(pos) >= seq_len) r.status = ST_RANGE;
        else r.read_value = seq_words[pos];
      end
      FN_SORT: begin
        // ascending, signed compares
        for (i = 1; i < seq_len; i++) begin
          w = seq_words[i];
          j = i;
          while (j > 0 && seq_words[j-1] > w) begin
            seq_words[j] = seq_words[j-1];
            j--;
          end
          seq_words[j] = w;
        end
      end
      default: ;
    endcase
    r.count = seq_len[COUNT_W-1:0];
    return r;
  endfunction

  // send one request beat; entered and left at a falling edge
  task automatic send_request(input logic [FUNC_W-1:0] fn,
                              input logic [WORD_W-1:0] word,
                              input logic [POS_W-1:0] pos);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, pos, word};
    s_axis_tuser <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_request(fn, word, pos));
    @(negedge clk_i);
  endtask

  // hold off the sender until every outstanding answer is back
  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // requests against an empty store, plus the undefined codes
  task automatic test_empty_store();
    send_request(FN_READ, 32'h0, 6'd0);
    send_request(FN_READ, 32'h0, 6'd63);
    send_request(FN_DELETE, 32'h0, 6'd0);
    send_request(FN_SORT, 32'h0, 6'd0);
    send_request(FN_SPARE_6, WORD_NEG1, 6'd63);
    send_request(FN_SPARE_7, WORD_MIN, 6'd0);
    send_request(FN_INS_AT, 32'h1234_5678, 6'd1);
  endtask

  // extreme words, insert at count, out-of-range indexes, small sorts
  task automatic test_edges_and_range();
    send_request(FN_INS_AT, WORD_MAX, 6'd0);
    send_request(FN_SORT, 32'h0, 6'd0);
    send_request(FN_INS_BACK, WORD_MIN, 6'd0);
    send_request(FN_INS_FRONT, WORD_NEG1, 6'd0);
    send_request(FN_INS_AT, 32'h0, 6'd3);
    send_request(FN_INS_AT, 32'h5a5a_a5a5, 6'd63);
    send_request(FN_READ, 32'h0, 6'd63);
    send_request(FN_READ, 32'h0, 6'd4);
    send_request(FN_DELETE, 32'h0, 6'd4);
    send_request(FN_INS_AT, 32'h0000_0001, 6'd2);
    send_request(FN_SORT, 32'h0, 6'd0);
    send_request(FN_READ, 32'h0, 6'd0);
    send_request(FN_READ, 32'h0, 6'd4);
    send_request(FN_DELETE, 32'h0, 6'd4);
    send_request(FN_DELETE, 32'h0, 6'd0);
    send_request(FN_READ, 32'h0, 6'd1);
    send_request(FN_SPARE_7, 32'h0, 6'd1);
  endtask

  // random traffic in phases that fill, drain or churn the store
  task automatic test_random_traffic(input int target);
    int sent;
    int phase_left;
    int roll;
    mix_e mix;
    logic [FUNC_W-1:0] fn;
    logic [WORD_W-1:0] word;
    logic [POS_W-1:0] pos;
    sent = 0;
    phase_left = 0;
    mix = MIX_BALANCED;
    while (sent < target) begin
      if (phase_left == 0) begin
        mix = mix_e'($urandom_range(0, 2));
        case (mix)
          MIX_GROW:   phase_left = $urandom_range(8, 25);
          MIX_SHRINK: phase_left = $urandom_range(5, 15);
          default:    phase_left = $urandom_range(30, 150);
        endcase
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 7) == 0) wait_for_results();
      end

      // pick the request kind for this phase
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        fn = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;
      end else begin
        case (mix)
          MIX_GROW:   roll = (roll < 73) ? 0 : (roll < 85) ? 1 : (roll < 95) ? 2 : 3;
          MIX_SHRINK: roll = (roll < 15) ? 0 : (roll < 30) ? 1 : (roll < 97) ? 2 : 3;
          default:    roll = (roll < 38) ? 0 : (roll < 65) ? 1 : (roll < 95) ? 2 : 3;
        endcase
        case (roll)
          0: begin
            case ($urandom_range(0, 2))
              0:       fn = FN_INS_FRONT;
              1:       fn = FN_INS_BACK;
              default: fn = FN_INS_AT;
            endcase
          end
          1:       fn = FN_READ;
          2:       fn = FN_DELETE;
          default: fn = FN_SORT;
        endcase
      end

      // extremes and small values now and then, so sorts see duplicates
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0:       word = WORD_MAX;
            1:       word = WORD_MIN;
            2:       word = WORD_NEG1;
            default: word = '0;
          endcase
        end
        1, 2:    word = WORD_W'($urandom_range(0, 15)) - 32'd8;
        default: word = $urandom;
      endcase

      // mostly legal indexes, some anywhere in the field
      if ($urandom_range(0, 6) == 0) pos = POS_W'($urandom_range(0, 63));
      else if (fn == FN_INS_AT) pos = POS_W'($urandom_range(0, (seq_len > 63) ? 63 : seq_len));
      else if (seq_len > 0) pos = POS_W'($urandom_range(0, seq_len - 1));
      else pos = '0;

      send_request(fn, word, pos);
      if (fn != FN_SPARE_6 && fn != FN_SPARE_7) sent++;
      if ((mix == MIX_GROW && seq_len == CAPACITY) ||
          (mix == MIX_SHRINK && seq_len == 0) || mix == MIX_BALANCED) begin
        phase_left--;
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // result side: random stalls, every beat checked against the oldest expectation
  initial begin : result_checker
    int stall;
    result_t got;
    result_t want;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.read_value = m_axis_tdata[WORD_W-1:0];
      got.count = m_axis_tdata[WORD_W +: COUNT_W];
      got.status = status_e'(m_axis_tuser);
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected beat: value %h count %0d status %0d",
                               got.read_value, got.count, got.status));
      end else begin
        want = pending_results.pop_front();
        if (got.read_value !== want.read_value || got.count !== want.count ||
            got.status !== want.status) begin
          note_failure($sformatf(
            "mismatch: expected value %h count %0d status %0d, got value %h count %0d status %0d",
            want.read_value, want.count, want.status,
            got.read_value, got.count, got.status));
        end
      end
      @(negedge clk_i);
    end
  end

  // reset, then the tests in turn
  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    seq_len = 0;
    fail_count = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_store();
    test_edges_and_range();
    wait_for_results();
    test_random_traffic(1950);

    // drain, then give a long sort time to show any stray beat
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (CAPACITY + 20) @(negedge clk_i);
    if (pending_results.size() != 0) begin
      note_failure($sformatf("%0d answers never arrived", pending_results.size()));
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
